/* rtl/circle_fan_vertex_generator_macros.svh */
// Assertion helpers shared by the RTL. Each expects signals named clk and rst
// in the module where it is used.
`ifndef CIRCLE_FAN_VERTEX_GENERATOR_MACROS_SVH
`define CIRCLE_FAN_VERTEX_GENERATOR_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CFVG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define CFVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cfvg_pkg.sv */
`timescale 1ns / 1ps

package cfvg_pkg;

  localparam int IDX_W   = 6;
  localparam int PHASE_W = 32;
  localparam int NQ_W    = IDX_W + PHASE_W;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int COUNT_W = 7;
  localparam int RAD_W   = 31;

  localparam int DEF_MAX_SEGMENTS  = 64;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int MIN_SEGMENTS      = 3;

  localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;

  localparam logic signed [31:0]  RESET_CENTER = 32'sd0;
  localparam logic [RAD_W-1:0]    RESET_RADIUS = 31'd65536;
  localparam logic [COUNT_W-1:0]  RESET_COUNT  = 7'd16;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_SEG_COUNT = 2'd3
  } reg_idx_t;

  // Index bookkeeping that rides along with every item.
  typedef struct packed {
    logic             hub;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] third;
  } tag_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
    tag_t               tag;
  } cord_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] a;
    a = '0;
    if (k < ATAN_ENTRIES) begin
      a = ATAN_TURNS[k];
    end
    return a;
  endfunction

endpackage

/* rtl/cfvg_div_cell.sv */
`timescale 1ns / 1ps

// One restoring division step. The numerator bits leave at the top of nq
// while quotient bits enter at the bottom, so after NQ_W cells nq holds
// the quotient.
module cfvg_div_cell
  import cfvg_pkg::*;
#(
  parameter int NW = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [NW-1:0]    seg_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [NW-1:0]    up_rem,
  input  logic [NQ_W-1:0]  up_nq,
  input  tag_t             up_tag,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [NW-1:0]    dn_rem,
  output logic [NQ_W-1:0]  dn_nq,
  output tag_t             dn_tag
);

  logic [NW:0]     shifted;
  logic [NW:0]     diff;
  logic            ge;
  logic [NW-1:0]   rem_next;
  logic [NQ_W-1:0] nq_next;

  always_comb begin
    shifted  = {up_rem, up_nq[NQ_W-1]};
    ge       = shifted >= {1'b0, seg_n};
    diff     = shifted - {1'b0, seg_n};
    rem_next = ge ? diff[NW-1:0] : shifted[NW-1:0];
    nq_next  = {up_nq[NQ_W-2:0], ge};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_rem <= rem_next;
      dn_nq  <= nq_next;
      dn_tag <= up_tag;
    end
  end

endmodule

/* rtl/cfvg_cordic_cell.sv */
`timescale 1ns / 1ps

// One CORDIC rotation step; STAGE sets the shift and the arctangent.
module cfvg_cordic_cell
  import cfvg_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  cord_t up,
  output logic  dn_valid,
  input  logic  dn_ready,
  output cord_t dn
);

  localparam logic [31:0] ATAN = atan_turn(STAGE);

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  cord_t              nxt;

  always_comb begin
    dx  = up.y >>> STAGE;
    dy  = up.x >>> STAGE;
    nxt = up;
    if (!up.z[31]) begin
      nxt.x = up.x - dx;
      nxt.y = up.y + dy;
      nxt.z = up.z - $signed(ATAN);
    end else begin
      nxt.x = up.x + dx;
      nxt.y = up.y - dy;
      nxt.z = up.z + $signed(ATAN);
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= nxt;
    end
  end

endmodule

/* rtl/cfvg_place.sv */
`timescale 1ns / 1ps

// Quadrant fold and radius scaling, then rounding, center offset and
// saturation. Two register stages; the second is the output register.
module cfvg_place
  import cfvg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [RAD_W-1:0]        radius,
  input  logic signed [31:0]      center_x,
  input  logic signed [31:0]      center_y,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  cord_t                   up,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [IDX_W-1:0]        tri_first,
  output logic [IDX_W-1:0]        tri_third
);

  localparam logic signed [65:0] ROUND_HALF = 66'sh2000_0000;
  localparam logic signed [36:0] SAT_MAX    = 37'sh0_7FFF_FFFF;
  localparam logic signed [36:0] SAT_MIN    = -37'sh0_8000_0000;

  logic signed [32:0] cx;
  logic signed [32:0] sy;
  logic signed [32:0] ux;
  logic signed [32:0] uy;
  logic signed [32:0] rad_s;
  logic signed [65:0] prod_x_next;
  logic signed [65:0] prod_y_next;

  logic               mid_valid;
  logic               mid_ready;
  logic signed [65:0] prod_x;
  logic signed [65:0] prod_y;
  tag_t               mid_tag;

  logic signed [65:0] rnd_x;
  logic signed [65:0] rnd_y;
  logic signed [36:0] sum_x;
  logic signed [36:0] sum_y;
  logic signed [31:0] pos_x_next;
  logic signed [31:0] pos_y_next;

  always_comb begin
    cx = {up.x[31], up.x};
    sy = {up.y[31], up.y};
    case (up.quad)
      2'd0:    begin ux = cx;  uy = sy;  end
      2'd1:    begin ux = -sy; uy = cx;  end
      2'd2:    begin ux = -cx; uy = -sy; end
      default: begin ux = sy;  uy = -cx; end
    endcase
    rad_s       = $signed({2'b00, radius});
    prod_x_next = rad_s * ux;
    prod_y_next = rad_s * uy;
  end

  assign up_ready  = !mid_valid || mid_ready;
  assign mid_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      dn_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        mid_valid <= up_valid;
      end
      if (mid_ready) begin
        dn_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_x  <= prod_x_next;
      prod_y  <= prod_y_next;
      mid_tag <= up.tag;
    end
  end

  always_comb begin
    rnd_x = prod_x + ROUND_HALF;
    rnd_y = prod_y + ROUND_HALF;
    // Bits 30 and up of the rounded product are the floor of the offset.
    sum_x = {{5{center_x[31]}}, center_x} + {rnd_x[65], rnd_x[65:30]};
    sum_y = {{5{center_y[31]}}, center_y} + {rnd_y[65], rnd_y[65:30]};
    if (mid_tag.hub) begin
      pos_x_next = center_x;
      pos_y_next = center_y;
    end else begin
      if (sum_x > SAT_MAX) begin
        pos_x_next = SAT_MAX[31:0];
      end else if (sum_x < SAT_MIN) begin
        pos_x_next = SAT_MIN[31:0];
      end else begin
        pos_x_next = sum_x[31:0];
      end
      if (sum_y > SAT_MAX) begin
        pos_y_next = SAT_MAX[31:0];
      end else if (sum_y < SAT_MIN) begin
        pos_y_next = SAT_MIN[31:0];
      end else begin
        pos_y_next = sum_y[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      tri_first <= mid_tag.idx;
      tri_third <= mid_tag.third;
    end
  end

endmodule

/* rtl/circle_fan_vertex_generator.sv */
`timescale 1ns / 1ps
// Circle fan vertex generator.
// Input channel: segment_index with in_valid/in_ready. Output channel: pos_x,
// pos_y (signed Q16.16), tri_first and tri_third with out_valid/out_ready.
// Configuration goes through the APB port: center_x at 0x0, center_y at 0x4,
// circle_radius at 0x8, segment_count at 0xC; write only while no item is in
// flight. pready is always high and reads return the register value.
// Each item travels through 38 divider cells (one quotient bit per cell),
// CORDIC_STAGES rotation cells and two scaling stages.
// One item is accepted per cycle when the output side keeps up.
// When the receiver stalls, the chain fills up behind the output register,
// empty cells close up, and in_ready falls only once every cell holds an item.
// Synchronous reset empties the chain and restores center (0, 0), radius 1.0
// and 16 segments.
module circle_fan_vertex_generator
  import cfvg_pkg::*;
#(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic [IDX_W-1:0]        segment_index,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [IDX_W-1:0]        tri_first,
  output logic [IDX_W-1:0]        tri_third,
  output logic                    out_valid,
  input  logic                    out_ready
);

  `include "circle_fan_vertex_generator_macros.svh"

  localparam int NW = $clog2(MAX_SEGMENTS + 1);

  logic signed [31:0]  center_x;
  logic signed [31:0]  center_y;
  logic [RAD_W-1:0]    circle_radius;
  logic [COUNT_W-1:0]  segment_count;
  reg_idx_t            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= RESET_CENTER;
      center_y      <= RESET_CENTER;
      circle_radius <= RESET_RADIUS;
      segment_count <= RESET_COUNT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_CENTER_X:  center_x      <= $signed(pwdata);
        REG_CENTER_Y:  center_y      <= $signed(pwdata);
        REG_RADIUS:    circle_radius <= pwdata[RAD_W-1:0];
        REG_SEG_COUNT: segment_count <= pwdata[COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CENTER_X:  prdata = center_x;
      REG_CENTER_Y:  prdata = center_y;
      REG_RADIUS:    prdata = {1'b0, circle_radius};
      REG_SEG_COUNT: prdata = DATA_W'(segment_count);
    endcase
  end

  // Effective segment count, clamped to the supported range.
  logic [NW-1:0]    seg_n;
  logic [IDX_W:0]   third_full;
  tag_t             in_tag;

  always_comb begin
    if (int'(segment_count) < MIN_SEGMENTS) begin
      seg_n = NW'(MIN_SEGMENTS);
    end else if (int'(segment_count) > MAX_SEGMENTS) begin
      seg_n = NW'(MAX_SEGMENTS);
    end else begin
      seg_n = NW'(segment_count);
    end
    third_full   = (IDX_W + 1)'(segment_index) + (IDX_W + 1)'(1);
    in_tag.hub   = segment_index == '0;
    in_tag.idx   = segment_index;
    if (int'(third_full) >= int'(seg_n)) begin
      in_tag.third = IDX_W'(1);
    end else begin
      in_tag.third = third_full[IDX_W-1:0];
    end
  end

  // Divider chain: phase = round(index * 2^32 / n), kept modulo one turn.
  logic [NQ_W:0]    div_valid;
  logic [NQ_W:0]    div_ready;
  logic [NW-1:0]    div_rem [NQ_W];
  logic [NQ_W-1:0]  div_nq  [NQ_W+1];
  tag_t             div_tag [NQ_W+1];

  assign div_valid[0] = in_valid;
  assign in_ready     = div_ready[0];
  assign div_rem[0]   = '0;
  assign div_nq[0]    = {segment_index, PHASE_W'(seg_n >> 1)};
  assign div_tag[0]   = in_tag;

  for (genvar k = 0; k < NQ_W; k++) begin : g_div
    if (k == NQ_W - 1) begin : g_last
      cfvg_div_cell #(.NW(NW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .seg_n    (seg_n),
        .up_valid (div_valid[k]),
        .up_ready (div_ready[k]),
        .up_rem   (div_rem[k]),
        .up_nq    (div_nq[k]),
        .up_tag   (div_tag[k]),
        .dn_valid (div_valid[k+1]),
        .dn_ready (div_ready[k+1]),
        .dn_rem   (),
        .dn_nq    (div_nq[k+1]),
        .dn_tag   (div_tag[k+1])
      );
    end else begin : g_mid
      cfvg_div_cell #(.NW(NW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .seg_n    (seg_n),
        .up_valid (div_valid[k]),
        .up_ready (div_ready[k]),
        .up_rem   (div_rem[k]),
        .up_nq    (div_nq[k]),
        .up_tag   (div_tag[k]),
        .dn_valid (div_valid[k+1]),
        .dn_ready (div_ready[k+1]),
        .dn_rem   (div_rem[k+1]),
        .dn_nq    (div_nq[k+1]),
        .dn_tag   (div_tag[k+1])
      );
    end
  end

  // CORDIC chain over the residual angle within one quadrant.
  logic [CORDIC_STAGES:0] cord_valid;
  logic [CORDIC_STAGES:0] cord_ready;
  cord_t                  cord [CORDIC_STAGES+1];
  logic [PHASE_W-1:0]     phase;

  assign phase                = div_nq[NQ_W][PHASE_W-1:0];
  assign cord_valid[0]        = div_valid[NQ_W];
  assign div_ready[NQ_W]      = cord_ready[0];
  assign cord[0].x            = CORDIC_GAIN_INV;
  assign cord[0].y            = '0;
  assign cord[0].z            = $signed({2'b00, phase[PHASE_W-3:0]});
  assign cord[0].quad         = phase[PHASE_W-1:PHASE_W-2];
  assign cord[0].tag          = div_tag[NQ_W];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    cfvg_cordic_cell #(.STAGE(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cord_valid[k]),
      .up_ready (cord_ready[k]),
      .up       (cord[k]),
      .dn_valid (cord_valid[k+1]),
      .dn_ready (cord_ready[k+1]),
      .dn       (cord[k+1])
    );
  end

  cfvg_place u_place (
    .clk       (clk),
    .rst       (rst),
    .radius    (circle_radius),
    .center_x  (center_x),
    .center_y  (center_y),
    .up_valid  (cord_valid[CORDIC_STAGES]),
    .up_ready  (cord_ready[CORDIC_STAGES]),
    .up        (cord[CORDIC_STAGES]),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .tri_first (tri_first),
    .tri_third (tri_third)
  );

  `CFVG_ASSERT_IMP(a_backpressure_only_when_full, !in_ready, out_valid && !out_ready,
    "input stalled although the output side is not stalled")
  `CFVG_ASSERT_NEXT(a_accept_enters_chain, in_valid && in_ready, div_valid[1],
    "accepted item did not enter the first divider cell")
  `CFVG_ASSERT_IMP(a_third_differs, out_valid, tri_third != tri_first,
    "third fan index equals the first one")

endmodule

/* tb/cfvg_vertex_checker.sv */
`timescale 1ns / 1ps

module cfvg_vertex_checker
  import cfvg_pkg::*;
#(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [IDX_W-1:0]   segment_index,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [IDX_W-1:0]   tri_first,
  input  logic [IDX_W-1:0]   tri_third,
  input  logic               out_valid,
  input  logic               out_ready,
  output int                 error_count,
  output int                 pending
);

  localparam longint UNIT_GAIN = 64'sd652032874;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   third;
  } vertex_t;

  logic signed [31:0] ctr_x;
  logic signed [31:0] ctr_y;
  logic [RAD_W-1:0]   radius;
  logic [COUNT_W-1:0] seg_count;

  vertex_t awaited_vertices[$];
  int      errors_seen = 0;
  int      depth = 0;

  assign error_count = errors_seen;
  assign pending     = depth;

  // Arctangent of 2^-k in turn units (2^32 per turn).
  function automatic longint arctan_turn(input int k);
    longint a;
    case (k)
      0:  a = 64'h20000000;
      1:  a = 64'h12E4051E;
      2:  a = 64'h09FB385B;
      3:  a = 64'h051111D4;
      4:  a = 64'h028B0D43;
      5:  a = 64'h0145D7E1;
      6:  a = 64'h00A2F61E;
      7:  a = 64'h00517C55;
      8:  a = 64'h0028BE53;
      9:  a = 64'h00145F2F;
      10: a = 64'h000A2F98;
      11: a = 64'h000517CC;
      12: a = 64'h00028BE6;
      13: a = 64'h000145F3;
      14: a = 64'h0000A2FA;
      15: a = 64'h0000517D;
      16: a = 64'h000028BE;
      17: a = 64'h0000145F;
      18: a = 64'h00000A30;
      19: a = 64'h00000518;
      20: a = 64'h0000028C;
      21: a = 64'h00000146;
      22: a = 64'h000000A3;
      23: a = 64'h00000051;
      default: a = 0;
    endcase
    return a;
  endfunction

  // Scales a Q2.30 unit component by the radius, rounds, adds the center and saturates.
  function automatic logic signed [31:0] place_axis(input logic signed [31:0] center,
                                                    input longint unit);
    longint prod;
    longint off;
    longint sum;
    prod = longint'(radius) * unit;
    off  = (prod + 64'sd536870912) >>> 30;
    sum  = longint'(center) + off;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic vertex_t compute_vertex(input logic [IDX_W-1:0] idx);
    vertex_t         v;
    longint unsigned n;
    longint unsigned num;
    logic [31:0]     phase;
    logic [1:0]      quad;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          a;
    longint          ux;
    longint          uy;
    longint          t;
    n = longint'(seg_count);
    if (n < MIN_SEGMENTS) n = MIN_SEGMENTS;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    t = longint'(idx) + 1;
    if (t >= longint'(n)) t = 1;
    v.first = idx;
    v.third = t[IDX_W-1:0];
    if (idx == '0) begin
      v.x = ctr_x;
      v.y = ctr_y;
    end else begin
      num   = (longint'(idx) << 32) + (n >> 1);
      phase = 32'(num / n);
      quad  = phase[31:30];
      x = UNIT_GAIN;
      y = 0;
      z = longint'({34'd0, phase[29:0]});
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        a  = arctan_turn(k);
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - a;
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + a;
        end
      end
      case (quad)
        2'd0: begin ux = x;  uy = y;  end
        2'd1: begin ux = -y; uy = x;  end
        2'd2: begin ux = -x; uy = -y; end
        default: begin ux = y; uy = -x; end
      endcase
      v.x = place_axis(ctr_x, ux);
      v.y = place_axis(ctr_y, uy);
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    vertex_t want;
    if (rst) begin
      ctr_x     <= RESET_CENTER;
      ctr_y     <= RESET_CENTER;
      radius    <= RESET_RADIUS;
      seg_count <= RESET_COUNT;
      awaited_vertices.delete();
    end else begin
      if (in_valid && in_ready) begin
        awaited_vertices.push_back(compute_vertex(segment_index));
      end
      if (out_valid && out_ready) begin
        if (awaited_vertices.size() == 0) begin
          errors_seen++;
          $error("vertex item arrived with none outstanding");
        end else begin
          want = awaited_vertices.pop_front();
          if (pos_x !== want.x) begin
            errors_seen++;
            $error("pos_x: expected %0d, got %0d", want.x, pos_x);
          end
          if (pos_y !== want.y) begin
            errors_seen++;
            $error("pos_y: expected %0d, got %0d", want.y, pos_y);
          end
          if (tri_first !== want.first) begin
            errors_seen++;
            $error("tri_first: expected %0d, got %0d", want.first, tri_first);
          end
          if (tri_third !== want.third) begin
            errors_seen++;
            $error("tri_third: expected %0d, got %0d", want.third, tri_third);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CENTER_X:  ctr_x     <= pwdata;
          REG_CENTER_Y:  ctr_y     <= pwdata;
          REG_RADIUS:    radius    <= pwdata[RAD_W-1:0];
          REG_SEG_COUNT: seg_count <= pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    depth = awaited_vertices.size();
  end

endmodule

/* tb/tb_circle_fan_vertex_generator.sv */
`timescale 1ns / 1ps

module tb_circle_fan_vertex_generator
  import cfvg_pkg::*;
();

  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 80;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic [IDX_W-1:0]   segment_index;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [IDX_W-1:0]   tri_first;
  logic [IDX_W-1:0]   tri_third;
  logic               out_valid;
  logic               out_ready;
  int                 error_count;
  int                 pending;

  int in_gap_pct    = 0;
  int out_stall_pct = 0;

  circle_fan_vertex_generator DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .segment_index (segment_index),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .tri_first     (tri_first),
    .tri_third     (tri_third),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  cfvg_vertex_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .segment_index (segment_index),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .tri_first     (tri_first),
    .tri_third     (tri_third),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .error_count   (error_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("circle_fan_vertex_generator verification failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int g;
    if ($urandom_range(0, 9) == 0) g = $urandom_range(20, 60);
    else g = $urandom_range(1, 3);
    return g;
  endfunction

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < out_stall_pct) stall_left = pick_gap();
      end
    end
  end

  // All tasks below start and end at a falling edge.
  task automatic write_reg(input reg_idx_t r, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    gap = ($urandom_range(0, 99) < in_gap_pct) ? pick_gap() : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    segment_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers may only change once every item in flight has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] rad, input logic [31:0] cnt);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_SEG_COUNT, cnt);
  endtask

  function automatic logic [31:0] random_center();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0: c = 32'h7FFF_FFFF;
      1: c = 32'h8000_0000;
      2, 3: c = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: c = $urandom();
    endcase
    return c;
  endfunction

  function automatic logic [31:0] random_radius();
    logic [31:0] r;
    case ($urandom_range(0, 5))
      0: r = {$urandom_range(0, 1) == 1, 31'd0};
      1: r = {$urandom_range(0, 1) == 1, 31'h7FFF_FFFF};
      2, 3: r = $urandom_range(0, 32'h0040_0000);
      default: r = $urandom();
    endcase
    return r;
  endfunction

  function automatic logic [6:0] random_count();
    logic [6:0] n;
    case ($urandom_range(0, 7))
      0: n = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 2))
                                         : 7'($urandom_range(65, 127));
      1: n = ($urandom_range(0, 1) == 1) ? 7'd3 : 7'd64;
      default: n = 7'($urandom_range(3, 64));
    endcase
    return n;
  endfunction

  initial begin : stimulus
    int         sent;
    int         burst;
    int         eff_n;
    logic [6:0] cnt;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    segment_index = '0;
    in_valid      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: unit circle at the origin, 16 segments. Covers the hub,
    // the last index, an index equal to the count and the largest index.
    send_index(6'd0);
    send_index(6'd1);
    send_index(6'd4);
    send_index(6'd8);
    send_index(6'd12);
    send_index(6'd15);
    send_index(6'd16);
    send_index(6'd63);

    // Extreme center and radius, so pos_x saturates high and pos_y saturates low.
    set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF80 | 32'd64);
    send_index(6'd0);
    send_index(6'd1);
    send_index(6'd16);
    send_index(6'd32);
    send_index(6'd48);
    send_index(6'd63);

    // Smallest count and zero radius.
    set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd3);
    send_index(6'd0);
    send_index(6'd1);
    send_index(6'd2);
    send_index(6'd3);

    // Counts below the minimum and above the maximum are clamped.
    set_circle(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'd0);
    send_index(6'd1);
    send_index(6'd2);
    drain();
    write_reg(REG_SEG_COUNT, 32'd2);
    send_index(6'd2);
    drain();
    write_reg(REG_SEG_COUNT, 32'd127);
    send_index(6'd63);
    send_index(6'd33);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cnt = random_count();
      set_circle(random_center(), random_center(), random_radius(),
                 ($urandom() & 32'hFFFF_FF80) | {25'd0, cnt});
      eff_n = (cnt < MIN_SEGMENTS) ? MIN_SEGMENTS :
              (cnt > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : int'(cnt);
      case ($urandom_range(0, 3))
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 10; out_stall_pct = 5;  end
        2: begin in_gap_pct = 40; out_stall_pct = 10; end
        default: begin in_gap_pct = 5; out_stall_pct = 30; end
      endcase
      burst = $urandom_range(40, 120);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      for (int i = 0; i < burst; i++) begin
        // Mostly indices inside the fan, the rest anywhere in the field.
        if ($urandom_range(0, 99) < 85) send_index(IDX_W'($urandom_range(0, eff_n - 1)));
        else send_index(IDX_W'($urandom_range(0, 63)));
        sent++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("circle_fan_vertex_generator verification clean");
    end else begin
      $display("circle_fan_vertex_generator verification failed");
    end
    $finish;
  end

endmodule
